FILE: rtl/ray_box_nearest_hit_defines.svh
// ---------------------------------------------------------------------------
// ray box nearest hit assertion macros
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_NEAREST_HIT_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RBH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RBH_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RBH_ASSERT(label, clk, rst_n, prop)
`define RBH_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/rbh_pkg.sv
// ---------------------------------------------------------------------------
// rbh_pkg
// types and constants shared by the ray box nearest hit block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rbh_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH = 16;
    localparam int DIR_FRAC = 14;
    localparam int DATA_WIDTH = COORD_WIDTH_DEF;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_AXES = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_Z = 3'd5;

    typedef struct packed {
        logic [31:0] entity_id;
        logic signed [COORD_WIDTH_DEF-1:0] min_x;
        logic signed [COORD_WIDTH_DEF-1:0] min_y;
        logic signed [COORD_WIDTH_DEF-1:0] min_z;
        logic signed [COORD_WIDTH_DEF-1:0] max_x;
        logic signed [COORD_WIDTH_DEF-1:0] max_y;
        logic signed [COORD_WIDTH_DEF-1:0] max_z;
        logic last_box;
    } t_box_in;

    typedef struct packed {
        logic hit_found;
        logic [31:0] best_entity;
        logic [31:0] best_distance;
    } t_hit_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic [1:0] axis;
        logic side;
        logic div_start;
        logic store_t;
        logic finish;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic parallel;
        logic last;
    } t_status;
endpackage

FILE: rtl/ray_box_nearest_hit.sv
// ---------------------------------------------------------------------------
// ray_box_nearest_hit
// nearest forward hit of a configured ray against a stream of boxes
// ---------------------------------------------------------------------------
// usage:
//   the ray origin and direction are written through the config port while
//   the block is idle. boxes arrive on the input valid/ready channel, one
//   item per box; the box flagged last_box closes a pick and produces one
//   result item (hit flag, entity, distance) on the output channel.
//   each box is accepted, then per axis takes two divisions on the single
//   shared radix-2 divider (a start, 47 quotient bits at one per cycle,
//   a store of the quotient), then a finish step; a last box adds an
//   output step. a parallel axis does a containment check and no division.
//   the divider sets the rate: a new box is accepted only after the last
//   box is finished. the result is registered by the output step.
//   a result is held in an output register; the next box is accepted while
//   it waits. a second last box stalls until the receiver takes the first.
//   reset returns the ray to origin 0 looking along +z and clears the pick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ray_box_nearest_hit
    import rbh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_box_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_hit_out                 o_out_data
);
    t_cmd w_cmd;
    t_status w_status;

    rbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbh_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_box     (i_in_data),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_hit     (o_out_data)
    );
endmodule

FILE: rtl/rbh_divider.sv
// ---------------------------------------------------------------------------
// rbh_divider
// radix-2 restoring divider, signed operands, quotient truncated toward zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_box_nearest_hit_defines.svh"
module rbh_divider
    import rbh_pkg::*;
#(
    parameter int NUM_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [NUM_WIDTH-1:0] i_num,
    input  logic signed [DIR_WIDTH-1:0] i_den,
    output logic                        o_done,
    output logic signed [NUM_WIDTH:0]   o_quot
);
    localparam int CW = $clog2(NUM_WIDTH + 1);
    localparam int DW = DIR_WIDTH + 1;

    logic [NUM_WIDTH-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic r_neg;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [DW:0] w_trial;
    logic [NUM_WIDTH-1:0] w_anum;
    logic [DW-1:0] w_aden;

    assign w_anum = i_num[NUM_WIDTH-1] ? NUM_WIDTH'(-i_num) : NUM_WIDTH'(i_num);
    assign w_aden = i_den[DIR_WIDTH-1] ? DW'(-{i_den[DIR_WIDTH-1], i_den})
                                       : DW'({1'b0, i_den});

    always_comb begin
        w_trial = {r_rem, r_q[NUM_WIDTH-1]} - {1'b0, r_den};
        if (!w_trial[DW]) begin
            n_rem = w_trial[DW-1:0];
            n_q = {r_q[NUM_WIDTH-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[DW-2:0], r_q[NUM_WIDTH-1]};
            n_q = {r_q[NUM_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NUM_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_anum;
            r_rem <= '0;
            r_den <= w_aden;
            r_neg <= i_num[NUM_WIDTH-1] ^ i_den[DIR_WIDTH-1];
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    `RBH_ASSERT(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(r_busy))
endmodule

FILE: rtl/rbh_datapath.sv
// ---------------------------------------------------------------------------
// rbh_datapath
// ray registers, box registers, slab interval and nearest-hit tracking
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_box_nearest_hit_defines.svh"
module rbh_datapath
    import rbh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]    i_cfg_data,
    input  t_box_in                  i_box,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output t_hit_out                 o_hit
);
    localparam int COORD_WIDTH = COORD_WIDTH_DEF;
    // numerator width: coord diff (COORD_WIDTH+1) shifted by DIR_FRAC
    localparam int NW = COORD_WIDTH + 1 + DIR_FRAC;
    localparam int TW = NW + 1;

    logic signed [COORD_WIDTH-1:0] r_org [NUM_AXES];
    logic signed [DIR_WIDTH-1:0] r_dir [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_hi [NUM_AXES];
    logic [31:0] r_ent;
    logic r_last;
    logic r_degen;
    logic r_reject;
    logic r_tn_set, r_tf_set;
    logic signed [TW-1:0] r_tn, r_tf, r_t1;
    logic [31:0] r_best_d, r_best_e;
    logic r_any;
    t_hit_out r_out;

    logic w_div_done;
    logic signed [TW-1:0] w_quot;
    logic signed [COORD_WIDTH:0] w_diff;
    logic signed [NW-1:0] w_num;
    logic signed [COORD_WIDTH-1:0] w_o, w_b;
    logic signed [TW-1:0] w_lo_t, w_hi_t;
    logic signed [TW-1:0] w_t;
    logic [31:0] w_dist;
    logic w_par_out;

    assign w_o = r_org[i_cmd.axis];
    assign w_b = i_cmd.side ? r_hi[i_cmd.axis] : r_lo[i_cmd.axis];
    assign w_diff = (COORD_WIDTH+1)'(w_b) - (COORD_WIDTH+1)'(w_o);
    assign w_num = NW'(w_diff) <<< DIR_FRAC;

    rbh_divider #(.NUM_WIDTH(NW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (r_dir[i_cmd.axis]),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_par_out = (w_o < r_lo[i_cmd.axis]) || (w_o > r_hi[i_cmd.axis]);
    assign w_lo_t = (r_t1 > w_quot) ? w_quot : r_t1;
    assign w_hi_t = (r_t1 > w_quot) ? r_t1 : w_quot;

    always_comb begin
        w_t = (r_tn_set && r_tn > 0) ? r_tn : r_tf;
        if (!r_tf_set || w_t > TW'(33'h0_FFFF_FFFF)) w_dist = '1;
        else w_dist = w_t[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0; r_org[1] <= '0; r_org[2] <= '0;
            r_dir[0] <= '0; r_dir[1] <= '0; r_dir[2] <= 16'sd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_X: r_org[0] <= COORD_WIDTH'(signed'(i_cfg_data));
                REG_ORIGIN_Y: r_org[1] <= COORD_WIDTH'(signed'(i_cfg_data));
                REG_ORIGIN_Z: r_org[2] <= COORD_WIDTH'(signed'(i_cfg_data));
                REG_DIR_X:    r_dir[0] <= i_cfg_data[DIR_WIDTH-1:0];
                REG_DIR_Y:    r_dir[1] <= i_cfg_data[DIR_WIDTH-1:0];
                REG_DIR_Z:    r_dir[2] <= i_cfg_data[DIR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo[0] <= COORD_WIDTH'(i_box.min_x);
            r_lo[1] <= COORD_WIDTH'(i_box.min_y);
            r_lo[2] <= COORD_WIDTH'(i_box.min_z);
            r_hi[0] <= COORD_WIDTH'(i_box.max_x);
            r_hi[1] <= COORD_WIDTH'(i_box.max_y);
            r_hi[2] <= COORD_WIDTH'(i_box.max_z);
            r_ent <= i_box.entity_id;
            r_last <= i_box.last_box;
            r_degen <= (i_box.min_x == i_box.max_x) && (i_box.min_y == i_box.max_y)
                && (i_box.min_z == i_box.max_z);
        end
        if (i_cmd.emit) r_out <= '{hit_found: r_any,
            best_entity: r_any ? r_best_e : 32'd0,
            best_distance: r_any ? r_best_d : 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
            r_best_d <= '1;
            r_best_e <= '0;
            r_reject <= 1'b0;
            r_tn_set <= 1'b0;
            r_tf_set <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_reject <= 1'b0;
                r_tn_set <= 1'b0;
                r_tf_set <= 1'b0;
            end
            if (i_cmd.store_t) begin
                if (o_status.parallel) begin
                    if (w_par_out) r_reject <= 1'b1;
                end else if (!i_cmd.side) begin
                    r_t1 <= w_quot;
                end else begin
                    if (!r_tn_set || w_lo_t > r_tn) r_tn <= w_lo_t;
                    if (!r_tf_set || w_hi_t < r_tf) r_tf <= w_hi_t;
                    r_tn_set <= 1'b1;
                    r_tf_set <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (!r_degen && !r_reject && !(r_tn_set && r_tn > r_tf)
                        && !(r_tf_set && r_tf < 0)
                        && (!r_any || w_dist < r_best_d)) begin
                    r_any <= 1'b1;
                    r_best_d <= w_dist;
                    r_best_e <= r_ent;
                end
            end
            if (i_cmd.emit) begin
                r_any <= 1'b0;
                r_best_d <= '1;
                r_best_e <= '0;
            end
        end
    end

    assign o_status = '{div_done: w_div_done,
                        parallel: (r_dir[i_cmd.axis] == '0),
                        last: r_last};
    assign o_hit = r_out;

    `RBH_ASSERT(a_none_means_clear, i_clk, i_rst_n, !r_any |-> (r_best_e == '0))
    `RBH_ASSERT(a_emit_clears, i_clk, i_rst_n, i_cmd.emit |=> !r_any)
    `RBH_ASSERT(a_no_emit_and_load, i_clk, i_rst_n, !(i_cmd.emit && i_cmd.load))
endmodule

FILE: rtl/rbh_ctrl.sv
// ---------------------------------------------------------------------------
// rbh_ctrl
// sequencer: steps up to six slab divisions per box, then updates and, for a last box, emits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_box_nearest_hit_defines.svh"
module rbh_ctrl
    import rbh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic r_side, n_side;
    logic r_oval, n_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis <= '0;
            r_side <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis <= n_axis;
            r_side <= n_side;
            r_oval <= n_oval;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis = r_axis;
        n_side = r_side;
        n_oval = r_oval;
        o_cmd = '0;
        o_cmd.axis = r_axis;
        o_cmd.side = r_side;
        o_in_ready = 1'b0;
        if (r_oval && i_out_ready) n_oval = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_LOAD;
                    n_axis = '0;
                    n_side = 1'b0;
                end
            end
            ST_LOAD, ST_DIV_START: begin
                if (i_status.parallel) begin
                    // parallel axis: containment check, no division
                    o_cmd.store_t = 1'b1;
                    n_side = 1'b0;
                    if (r_axis == 2'd2) n_state = ST_FINISH;
                    else begin
                        n_axis = r_axis + 2'd1;
                        n_state = ST_DIV_START;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.store_t = 1'b1;
                    n_side = !r_side;
                    n_state = ST_DIV_START;
                    if (r_side) begin
                        if (r_axis == 2'd2) n_state = ST_FINISH;
                        else n_axis = r_axis + 2'd1;
                    end
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = i_status.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                // wait for the previous result to drain
                if (!r_oval || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_oval = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_oval;

    `RBH_ASSERT(a_emit_only_out, i_clk, i_rst_n, o_cmd.emit |-> (r_state == ST_OUT))
    `RBH_ASSERT(a_start_not_busy, i_clk, i_rst_n,
        o_cmd.div_start |=> (r_state == ST_DIV_WAIT))
endmodule
